[design/bbt_pkg.sv]
// shared types, codes and fixed point helpers of the billboard transform
`timescale 1ns / 1ps
package bbt_pkg;

  localparam int DW = 32;
  localparam int WW = 2 * DW;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DW-1:0] fx_t;
  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
  } vec3_t;

  // operands that ride along the pipeline next to the vector math
  typedef struct packed {
    vec3_t up;
    vec3_t n;
    vec3_t t;
  } side_t;

  typedef enum logic [1:0] {
    MODE_SCREEN = 2'd0,
    MODE_WORLD  = 2'd1,
    MODE_AXIS   = 2'd2,
    MODE_IDENT  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_POS_X   = 3'd1,
    REG_POS_Y   = 3'd2,
    REG_POS_Z   = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_SCALE_Z = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    COL_RIGHT  = 2'd0,
    COL_UP     = 2'd1,
    COL_NORMAL = 2'd2,
    COL_TRANS  = 2'd3
  } col_t;

  localparam wide_t FX_MAX = wide_t'(64'sd2147483647);
  localparam wide_t FX_MIN = -wide_t'(64'sd2147483648);

  // clamp a wide signed value to 32 bits
  function automatic fx_t sat32(input wide_t v);
    fx_t r;
    if (v > FX_MAX) begin
      r = fx_t'(FX_MAX);
    end else if (v < FX_MIN) begin
      r = fx_t'(FX_MIN);
    end else begin
      r = fx_t'(v);
    end
    return r;
  endfunction

  // drop frac fraction bits, ties toward plus infinity
  function automatic wide_t fx_round(input wide_t p, input int frac);
    wide_t half;
    half = wide_t'(1) <<< (frac - 1);
    return (p + half) >>> frac;
  endfunction

endpackage

[design/bbt_if.sv]
// valid/ready channels for camera beats and matrix column beats
`timescale 1ns / 1ps
interface bbt_in_if;
  logic        valid;
  logic        ready;
  bbt_pkg::fx_t cam_x;
  bbt_pkg::fx_t cam_y;
  bbt_pkg::fx_t cam_z;
  bbt_pkg::fx_t up_x;
  bbt_pkg::fx_t up_y;
  bbt_pkg::fx_t up_z;
  modport source (output valid, cam_x, cam_y, cam_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, up_x, up_y, up_z, output ready);
endinterface

interface bbt_out_if;
  logic          valid;
  logic          ready;
  bbt_pkg::col_t column;
  bbt_pkg::fx_t  elem_x;
  bbt_pkg::fx_t  elem_y;
  bbt_pkg::fx_t  elem_z;
  bbt_pkg::fx_t  elem_w;
  logic          last;
  modport source (output valid, column, elem_x, elem_y, elem_z, elem_w, last, input ready);
  modport sink (input valid, column, elem_x, elem_y, elem_z, elem_w, last, output ready);
endinterface

[design/billboard_transform.sv]
// An accepted camera beat passes the normalize, cross and scale stages to its first column beat;
// the four columns then follow on consecutive cycles while out ready is high.
// Sustained, one camera beat is taken per four column beats, set by the single column channel;
// the pipeline takes beats every cycle until it fills, and stalls as a whole on backpressure.
// Reset (rst_n low, synchronous): all stage valid bits clear, mode returns to screen aligned,
// position to zero and the scales to 1.0.
`timescale 1ns / 1ps
module billboard_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bbt_in_if.sink                            in_chan,
  bbt_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bbt_pkg::DW-1:0]            cfg_data
);

  localparam bbt_pkg::fx_t FX_ONE = bbt_pkg::fx_t'(1) << FRAC_BITS;

  bbt_pkg::mode_t mode_r;
  bbt_pkg::fx_t   pos_x_r, pos_y_r, pos_z_r;
  bbt_pkg::fx_t   scale_x_r, scale_y_r, scale_z_r;

  logic           adv;
  bbt_pkg::vec3_t yaxis;

  bbt_pkg::vec3_t d_nxt;
  bbt_pkg::vec3_t d_r;
  bbt_pkg::side_t d_side_r;
  logic           d_v_r;

  logic           n1_v;
  bbt_pkg::vec3_t n1_vec;
  bbt_pkg::side_t n1_side;
  bbt_pkg::vec3_t c1_a;
  bbt_pkg::side_t c1_side;

  logic           c1_v;
  bbt_pkg::vec3_t c1_vec;
  bbt_pkg::side_t c1_side_o;
  bbt_pkg::side_t n2_side_i;

  logic           n2_v;
  bbt_pkg::vec3_t n2_vec;
  bbt_pkg::side_t n2_side;
  bbt_pkg::side_t c2_side;

  logic           c2_v;
  bbt_pkg::vec3_t c2_vec;
  bbt_pkg::side_t c2_side_o;

  bbt_pkg::vec3_t u_sel;
  bbt_pkg::wide_t sp_nxt [9];
  bbt_pkg::wide_t sp_r [9];
  logic           sp_v_r;
  bbt_pkg::fx_t   mat_nxt [9];
  bbt_pkg::fx_t   sm_r [9];
  logic           sm_v_r;

  bbt_pkg::fx_t   mat_r [9];
  bbt_pkg::col_t  cnt_r;
  bbt_pkg::col_t  cnt_nxt;
  logic           busy_r;
  logic           load;

  assign yaxis = '{x: '0, y: FX_ONE, z: '0};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bbt_pkg::MODE_SCREEN;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      pos_z_r   <= '0;
      scale_x_r <= FX_ONE;
      scale_y_r <= FX_ONE;
      scale_z_r <= FX_ONE;
    end else if (cfg_we) begin
      case (bbt_pkg::reg_idx_t'(cfg_idx))
        bbt_pkg::REG_MODE:    mode_r    <= bbt_pkg::mode_t'(cfg_data[1:0]);
        bbt_pkg::REG_POS_X:   pos_x_r   <= cfg_data;
        bbt_pkg::REG_POS_Y:   pos_y_r   <= cfg_data;
        bbt_pkg::REG_POS_Z:   pos_z_r   <= cfg_data;
        bbt_pkg::REG_SCALE_X: scale_x_r <= cfg_data;
        bbt_pkg::REG_SCALE_Y: scale_y_r <= cfg_data;
        bbt_pkg::REG_SCALE_Z: scale_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // facing direction before normalizing
  always_comb begin
    d_nxt.x = bbt_pkg::sat32(bbt_pkg::wide_t'(in_chan.cam_x) - bbt_pkg::wide_t'(pos_x_r));
    d_nxt.y = bbt_pkg::sat32(bbt_pkg::wide_t'(in_chan.cam_y) - bbt_pkg::wide_t'(pos_y_r));
    d_nxt.z = bbt_pkg::sat32(bbt_pkg::wide_t'(in_chan.cam_z) - bbt_pkg::wide_t'(pos_z_r));
    case (mode_r)
      bbt_pkg::MODE_SCREEN: begin
        d_nxt.x = in_chan.cam_x;
        d_nxt.y = '0;
        d_nxt.z = in_chan.cam_z;
      end
      bbt_pkg::MODE_AXIS: begin
        d_nxt.y = '0;
      end
      default: ;
    endcase
  end

  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r         <= d_nxt;
      d_side_r.up <= '{x: in_chan.up_x, y: in_chan.up_y, z: in_chan.up_z};
      d_side_r.n  <= '0;
      d_side_r.t  <= '0;
    end
  end

  bbt_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_v_r),
    .in_vec   (d_r),
    .in_side  (d_side_r),
    .out_valid(n1_v),
    .out_vec  (n1_vec),
    .out_side (n1_side)
  );

  // normal (negated in screen mode), first cross operand
  always_comb begin
    c1_side    = n1_side;
    c1_side.n  = n1_vec;
    if (mode_r == bbt_pkg::MODE_SCREEN) begin
      c1_side.n.x = -n1_vec.x;
      c1_side.n.y = -n1_vec.y;
      c1_side.n.z = -n1_vec.z;
    end
    c1_a = (mode_r == bbt_pkg::MODE_AXIS) ? yaxis : n1_side.up;
  end

  bbt_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (n1_v),
    .in_a     (c1_a),
    .in_b     (c1_side.n),
    .in_side  (c1_side),
    .out_valid(c1_v),
    .out_vec  (c1_vec),
    .out_side (c1_side_o)
  );

  always_comb begin
    n2_side_i   = c1_side_o;
    n2_side_i.t = c1_vec;
  end

  bbt_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (c1_v),
    .in_vec   (c1_vec),
    .in_side  (n2_side_i),
    .out_valid(n2_v),
    .out_vec  (n2_vec),
    .out_side (n2_side)
  );

  // right vector is renormalized only in world mode
  always_comb begin
    c2_side = n2_side;
    if (mode_r == bbt_pkg::MODE_WORLD) begin
      c2_side.t = n2_vec;
    end
  end

  bbt_cross #(.FRAC_BITS(FRAC_BITS)) u_cross_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (n2_v),
    .in_a     (n2_side.n),
    .in_b     (n2_vec),
    .in_side  (c2_side),
    .out_valid(c2_v),
    .out_vec  (c2_vec),
    .out_side (c2_side_o)
  );

  // up column source per mode
  always_comb begin
    case (mode_r)
      bbt_pkg::MODE_WORLD: u_sel = c2_vec;
      bbt_pkg::MODE_AXIS:  u_sel = yaxis;
      default:             u_sel = c2_side_o.up;
    endcase
  end

  // scale products
  always_comb begin
    sp_nxt[0] = bbt_pkg::wide_t'(c2_side_o.t.x) * bbt_pkg::wide_t'(scale_x_r);
    sp_nxt[1] = bbt_pkg::wide_t'(c2_side_o.t.y) * bbt_pkg::wide_t'(scale_x_r);
    sp_nxt[2] = bbt_pkg::wide_t'(c2_side_o.t.z) * bbt_pkg::wide_t'(scale_x_r);
    sp_nxt[3] = bbt_pkg::wide_t'(u_sel.x) * bbt_pkg::wide_t'(scale_y_r);
    sp_nxt[4] = bbt_pkg::wide_t'(u_sel.y) * bbt_pkg::wide_t'(scale_y_r);
    sp_nxt[5] = bbt_pkg::wide_t'(u_sel.z) * bbt_pkg::wide_t'(scale_y_r);
    sp_nxt[6] = bbt_pkg::wide_t'(c2_side_o.n.x) * bbt_pkg::wide_t'(scale_z_r);
    sp_nxt[7] = bbt_pkg::wide_t'(c2_side_o.n.y) * bbt_pkg::wide_t'(scale_z_r);
    sp_nxt[8] = bbt_pkg::wide_t'(c2_side_o.n.z) * bbt_pkg::wide_t'(scale_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_v_r <= 1'b0;
    end else if (adv) begin
      sp_v_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r <= sp_nxt;
    end
  end

  // round and clamp the scaled elements
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mat_nxt[i] = bbt_pkg::sat32(bbt_pkg::fx_round(sp_r[i], FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (adv) begin
      sm_v_r <= sp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r <= mat_nxt;
    end
  end

  // column serializer: a new matrix loads when idle or as the previous translation beat leaves
  assign load = sm_v_r && (!busy_r || (out_chan.ready && cnt_r == bbt_pkg::COL_TRANS));
  assign adv  = !sm_v_r || load;

  always_comb begin
    case (cnt_r)
      bbt_pkg::COL_RIGHT:  cnt_nxt = bbt_pkg::COL_UP;
      bbt_pkg::COL_UP:     cnt_nxt = bbt_pkg::COL_NORMAL;
      bbt_pkg::COL_NORMAL: cnt_nxt = bbt_pkg::COL_TRANS;
      default:             cnt_nxt = bbt_pkg::COL_RIGHT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= bbt_pkg::COL_RIGHT;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= bbt_pkg::COL_RIGHT;
    end else if (busy_r && out_chan.ready) begin
      if (cnt_r == bbt_pkg::COL_TRANS) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mat_r <= sm_r;
    end
  end

  // column beat contents
  always_comb begin
    out_chan.valid  = busy_r;
    out_chan.column = cnt_r;
    out_chan.last   = (cnt_r == bbt_pkg::COL_TRANS);
    out_chan.elem_w = '0;
    case (cnt_r)
      bbt_pkg::COL_RIGHT: begin
        out_chan.elem_x = mat_r[0];
        out_chan.elem_y = mat_r[1];
        out_chan.elem_z = mat_r[2];
      end
      bbt_pkg::COL_UP: begin
        out_chan.elem_x = mat_r[3];
        out_chan.elem_y = mat_r[4];
        out_chan.elem_z = mat_r[5];
      end
      bbt_pkg::COL_NORMAL: begin
        out_chan.elem_x = mat_r[6];
        out_chan.elem_y = mat_r[7];
        out_chan.elem_z = mat_r[8];
      end
      default: begin
        out_chan.elem_x = pos_x_r;
        out_chan.elem_y = pos_y_r;
        out_chan.elem_z = pos_z_r;
        out_chan.elem_w = FX_ONE;
      end
    endcase
    // identity matrix overrides everything
    if (mode_r == bbt_pkg::MODE_IDENT) begin
      out_chan.elem_x = (cnt_r == bbt_pkg::COL_RIGHT)  ? FX_ONE : '0;
      out_chan.elem_y = (cnt_r == bbt_pkg::COL_UP)     ? FX_ONE : '0;
      out_chan.elem_z = (cnt_r == bbt_pkg::COL_NORMAL) ? FX_ONE : '0;
      out_chan.elem_w = (cnt_r == bbt_pkg::COL_TRANS)  ? FX_ONE : '0;
    end
  end

endmodule

[design/bbt_norm.sv]
// pipelined vector normalizer: squares, bitwise square root, restoring divides
`timescale 1ns / 1ps
module bbt_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  bbt_pkg::vec3_t in_vec,
  input  bbt_pkg::side_t in_side,
  output logic           out_valid,
  output bbt_pkg::vec3_t out_vec,
  output bbt_pkg::side_t out_side
);

  localparam int DW = bbt_pkg::DW;
  localparam int WW = bbt_pkg::WW;
  localparam int SQ_STEPS = DW;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int NW = DW + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  typedef struct packed {
    logic [2:0][WW-1:0] sq;
    logic [2:0][DW-1:0] mg;
    logic [2:0]         neg;
    bbt_pkg::side_t     side;
  } sq_stage_t;

  typedef struct packed {
    logic [WW-1:0]      x;
    logic [WW-1:0]      res;
    logic [2:0][DW-1:0] mg;
    logic [2:0]         neg;
    bbt_pkg::side_t     side;
  } rt_stage_t;

  typedef struct packed {
    logic [DW-1:0]      len;
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    bbt_pkg::side_t     side;
  } dv_stage_t;

  logic [2:0][DW-1:0] iv;
  sq_stage_t          sq_nxt;
  sq_stage_t          sq_r;
  logic               sq_v_r;
  rt_stage_t          rt0_nxt;
  rt_stage_t          rt_r [SQ_STEPS+1];
  logic [SQ_STEPS:0]  rt_v_r;
  dv_stage_t          dv0_nxt;
  dv_stage_t          dv_r [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_v_r;
  logic [2:0][DW-1:0] fin_nxt;
  logic [2:0][DW-1:0] fin_r;
  bbt_pkg::side_t     fin_side_r;
  logic               fin_v_r;

  assign iv = in_vec;

  // magnitudes and their squares
  always_comb begin
    sq_nxt.side = in_side;
    for (int i = 0; i < 3; i++) begin
      sq_nxt.neg[i] = iv[i][DW-1];
      sq_nxt.mg[i]  = iv[i][DW-1] ? (~iv[i] + DW'(1)) : iv[i];
      sq_nxt.sq[i]  = WW'(sq_nxt.mg[i]) * WW'(sq_nxt.mg[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (adv) begin
      sq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  // sum of squares seeds the root
  always_comb begin
    rt0_nxt.x    = sq_r.sq[0] + sq_r.sq[1] + sq_r.sq[2];
    rt0_nxt.res  = '0;
    rt0_nxt.mg   = sq_r.mg;
    rt0_nxt.neg  = sq_r.neg;
    rt0_nxt.side = sq_r.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (adv) begin
      rt_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_r[0] <= rt0_nxt;
    end
  end

  // one result bit of the integer square root per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_root
    localparam logic [WW-1:0] RBIT = WW'(1) << (WW - 2 - 2 * k);
    rt_stage_t     nxt;
    logic [WW-1:0] trial;

    always_comb begin
      nxt   = rt_r[k];
      trial = rt_r[k].res + RBIT;
      if (rt_r[k].x >= trial) begin
        nxt.x   = rt_r[k].x - trial;
        nxt.res = (rt_r[k].res >> 1) + RBIT;
      end else begin
        nxt.res = rt_r[k].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        rt_v_r[k+1] <= rt_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[k+1] <= nxt;
      end
    end
  end

  // numerators with the rounding half of the length folded in
  always_comb begin
    dv0_nxt.len  = rt_r[SQ_STEPS].res[DW-1:0];
    dv0_nxt.q    = '0;
    dv0_nxt.neg  = rt_r[SQ_STEPS].neg;
    dv0_nxt.side = rt_r[SQ_STEPS].side;
    for (int i = 0; i < 3; i++) begin
      dv0_nxt.rem[i] = {rt_r[SQ_STEPS].mg[i], {FRAC_BITS{1'b0}}}
                       + NW'(rt_r[SQ_STEPS].res[DW-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= rt_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // one quotient bit per stage, three components side by side
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int J = FRAC_BITS - s;
    dv_stage_t     nxt;
    logic [NW-1:0] dd;

    always_comb begin
      nxt = dv_r[s];
      dd  = NW'(dv_r[s].len) << J;
      for (int i = 0; i < 3; i++) begin
        if (dv_r[s].rem[i] >= dd) begin
          nxt.rem[i]  = dv_r[s].rem[i] - dd;
          nxt.q[i][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[s+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[s+1] <= dv_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[s+1] <= nxt;
      end
    end
  end

  // signs back on, zero vector stays zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_r[DIV_STEPS].len == '0) begin
        fin_nxt[i] = '0;
      end else if (dv_r[DIV_STEPS].neg[i]) begin
        fin_nxt[i] = -DW'(dv_r[DIV_STEPS].q[i]);
      end else begin
        fin_nxt[i] = DW'(dv_r[DIV_STEPS].q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r      <= fin_nxt;
      fin_side_r <= dv_r[DIV_STEPS].side;
    end
  end

  assign out_valid = fin_v_r;
  assign out_vec   = fin_r;
  assign out_side  = fin_side_r;

endmodule

[design/bbt_cross.sv]
// two stage cross product: six products, then rounding, difference and clamp
`timescale 1ns / 1ps
module bbt_cross #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  bbt_pkg::vec3_t in_a,
  input  bbt_pkg::vec3_t in_b,
  input  bbt_pkg::side_t in_side,
  output logic           out_valid,
  output bbt_pkg::vec3_t out_vec,
  output bbt_pkg::side_t out_side
);

  bbt_pkg::wide_t p_nxt [6];
  bbt_pkg::wide_t p_r [6];
  bbt_pkg::side_t p_side_r;
  logic           p_v_r;
  bbt_pkg::vec3_t o_nxt;
  bbt_pkg::vec3_t o_r;
  bbt_pkg::side_t o_side_r;
  logic           o_v_r;

  // full products
  always_comb begin
    p_nxt[0] = bbt_pkg::wide_t'(in_a.y) * bbt_pkg::wide_t'(in_b.z);
    p_nxt[1] = bbt_pkg::wide_t'(in_a.z) * bbt_pkg::wide_t'(in_b.y);
    p_nxt[2] = bbt_pkg::wide_t'(in_a.z) * bbt_pkg::wide_t'(in_b.x);
    p_nxt[3] = bbt_pkg::wide_t'(in_a.x) * bbt_pkg::wide_t'(in_b.z);
    p_nxt[4] = bbt_pkg::wide_t'(in_a.x) * bbt_pkg::wide_t'(in_b.y);
    p_nxt[5] = bbt_pkg::wide_t'(in_a.y) * bbt_pkg::wide_t'(in_b.x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= p_nxt;
      p_side_r <= in_side;
    end
  end

  // round each product, subtract, clamp
  always_comb begin
    o_nxt.x = bbt_pkg::sat32(bbt_pkg::fx_round(p_r[0], FRAC_BITS)
                             - bbt_pkg::fx_round(p_r[1], FRAC_BITS));
    o_nxt.y = bbt_pkg::sat32(bbt_pkg::fx_round(p_r[2], FRAC_BITS)
                             - bbt_pkg::fx_round(p_r[3], FRAC_BITS));
    o_nxt.z = bbt_pkg::sat32(bbt_pkg::fx_round(p_r[4], FRAC_BITS)
                             - bbt_pkg::fx_round(p_r[5], FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r      <= o_nxt;
      o_side_r <= p_side_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_vec   = o_r;
  assign out_side  = o_side_r;

endmodule

[design/bbt_chk.sv]
// port level checks on the column channel of the billboard transform
`timescale 1ns / 1ps
module bbt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_column,
  input logic       out_last
);

  // a stalled beat keeps its column
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column))
    else $error("column changed under backpressure");

  // last marks exactly the translation column
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_column == bbt_pkg::COL_TRANS)))
    else $error("last flag and column disagree");

  // columns of one matrix come back to back in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_column == $past(out_column) + 2'd1)
    else $error("column sequence broken");

  // a new matrix starts at the right column
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid || out_column == bbt_pkg::COL_RIGHT)
    else $error("matrix did not start at right column");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat offered out of reset");

endmodule

bind billboard_transform bbt_chk u_bbt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_column(out_chan.column),
  .out_last  (out_chan.last)
);

[tb/bbt_checker.sv]
// billboard transform checker: watches the channels, predicts the matrix columns and compares
`timescale 1ns / 1ps
module bbt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  bbt_in_if                             in_mon,
  bbt_out_if                            out_mon,
  input  logic                          cfg_we,
  input  logic [bbt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bbt_pkg::DW-1:0]        cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;

  typedef struct {
    bbt_pkg::col_t column;
    bbt_pkg::fx_t  x;
    bbt_pkg::fx_t  y;
    bbt_pkg::fx_t  z;
    bbt_pkg::fx_t  w;
    logic          last;
  } column_beat_t;

  column_beat_t columns_due[$];

  bbt_pkg::mode_t cur_mode;
  longint pos_q[3];
  longint scale_q[3];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // fixed point product, ties toward plus infinity
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic void cross_fx(input longint a[3], input longint b[3],
                                   output longint o[3]);
    o[0] = clamp32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
    o[1] = clamp32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
    o[2] = clamp32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // normalize, zero vector stays zero
  function automatic void unit_fx(input longint v[3], output longint o[3]);
    longint unsigned sum;
    longint unsigned len;
    longint unsigned m;
    longint unsigned q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      sum = sum + m * m;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = ((m << FRAC) + len / 2) / len;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic void push_column(input bbt_pkg::col_t c, input longint x,
                                      input longint y, input longint z, input longint w);
    column_beat_t b;
    b.column = c;
    b.x = bbt_pkg::fx_t'(x);
    b.y = bbt_pkg::fx_t'(y);
    b.z = bbt_pkg::fx_t'(z);
    b.w = bbt_pkg::fx_t'(w);
    b.last = (c == bbt_pkg::COL_TRANS);
    columns_due.push_back(b);
  endfunction

  // build the four expected columns of one camera beat
  function automatic void predict_matrix(input longint cam[3], input longint up[3]);
    longint d[3], n[3], r[3], u[3], t[3], yax[3];
    if (cur_mode == bbt_pkg::MODE_IDENT) begin
      push_column(bbt_pkg::COL_RIGHT, ONE, 0, 0, 0);
      push_column(bbt_pkg::COL_UP, 0, ONE, 0, 0);
      push_column(bbt_pkg::COL_NORMAL, 0, 0, ONE, 0);
      push_column(bbt_pkg::COL_TRANS, 0, 0, 0, ONE);
      return;
    end
    if (cur_mode == bbt_pkg::MODE_SCREEN) begin
      d[0] = cam[0]; d[1] = 0; d[2] = cam[2];
      unit_fx(d, n);
      for (int i = 0; i < 3; i++) n[i] = -n[i];
      u = up;
      cross_fx(u, n, r);
    end else if (cur_mode == bbt_pkg::MODE_WORLD) begin
      for (int i = 0; i < 3; i++) d[i] = clamp32(cam[i] - pos_q[i]);
      unit_fx(d, n);
      cross_fx(up, n, t);
      unit_fx(t, r);
      cross_fx(n, r, u);
    end else begin
      d[0] = clamp32(cam[0] - pos_q[0]); d[1] = 0; d[2] = clamp32(cam[2] - pos_q[2]);
      unit_fx(d, n);
      yax[0] = 0; yax[1] = ONE; yax[2] = 0;
      cross_fx(yax, n, r);
      u = yax;
    end
    push_column(bbt_pkg::COL_RIGHT, clamp32(fx_mul(r[0], scale_q[0])),
                clamp32(fx_mul(r[1], scale_q[0])), clamp32(fx_mul(r[2], scale_q[0])), 0);
    push_column(bbt_pkg::COL_UP, clamp32(fx_mul(u[0], scale_q[1])),
                clamp32(fx_mul(u[1], scale_q[1])), clamp32(fx_mul(u[2], scale_q[1])), 0);
    push_column(bbt_pkg::COL_NORMAL, clamp32(fx_mul(n[0], scale_q[2])),
                clamp32(fx_mul(n[1], scale_q[2])), clamp32(fx_mul(n[2], scale_q[2])), 0);
    push_column(bbt_pkg::COL_TRANS, pos_q[0], pos_q[1], pos_q[2], ONE);
  endfunction

  initial pending = 0;

  always @(posedge clk) begin
    longint cam[3], up[3];
    column_beat_t e;
    if (!rst_n) begin
      cur_mode <= bbt_pkg::MODE_SCREEN;
      pos_q = '{0, 0, 0};
      scale_q = '{ONE, ONE, ONE};
      fail_count = 0;
    end else begin
      // register shadow
      if (cfg_we) begin
        case (cfg_idx)
          bbt_pkg::REG_MODE:    cur_mode <= bbt_pkg::mode_t'(cfg_data[1:0]);
          bbt_pkg::REG_POS_X:   pos_q[0] = longint'(bbt_pkg::fx_t'(cfg_data));
          bbt_pkg::REG_POS_Y:   pos_q[1] = longint'(bbt_pkg::fx_t'(cfg_data));
          bbt_pkg::REG_POS_Z:   pos_q[2] = longint'(bbt_pkg::fx_t'(cfg_data));
          bbt_pkg::REG_SCALE_X: scale_q[0] = longint'(bbt_pkg::fx_t'(cfg_data));
          bbt_pkg::REG_SCALE_Y: scale_q[1] = longint'(bbt_pkg::fx_t'(cfg_data));
          bbt_pkg::REG_SCALE_Z: scale_q[2] = longint'(bbt_pkg::fx_t'(cfg_data));
          default: ;
        endcase
      end
      // camera beat accepted
      if (in_mon.valid && in_mon.ready) begin
        cam[0] = longint'(in_mon.cam_x);
        cam[1] = longint'(in_mon.cam_y);
        cam[2] = longint'(in_mon.cam_z);
        up[0] = longint'(in_mon.up_x);
        up[1] = longint'(in_mon.up_y);
        up[2] = longint'(in_mon.up_z);
        predict_matrix(cam, up);
      end
      // column beat accepted
      if (out_mon.valid && out_mon.ready) begin
        if (columns_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected column beat col=%0d", out_mon.column);
        end else begin
          e = columns_due.pop_front();
          if (out_mon.column !== e.column || out_mon.elem_x !== e.x ||
              out_mon.elem_y !== e.y || out_mon.elem_z !== e.z ||
              out_mon.elem_w !== e.w || out_mon.last !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch exp col=%0d %h %h %h %h l=%b got col=%0d %h %h %h %h l=%b",
                       e.column, e.x, e.y, e.z, e.w, e.last, out_mon.column,
                       out_mon.elem_x, out_mon.elem_y, out_mon.elem_z, out_mon.elem_w,
                       out_mon.last);
          end
        end
      end
    end
    pending = columns_due.size();
  end

endmodule

[tb/tb_billboard_transform.sv]
// billboard transform testbench top: clock, reset, stimulus, configuration and verdict
`timescale 1ns / 1ps
module tb_billboard_transform;

  localparam logic [bbt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int  LIMIT = 400000;
  localparam bbt_pkg::fx_t FX_ONE = 32'sd65536;
  localparam bbt_pkg::fx_t FX_LO = 32'sh80000000;
  localparam bbt_pkg::fx_t FX_HI = 32'sh7fffffff;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bbt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [bbt_pkg::DW-1:0] cfg_data;
  int fail_count;
  int pending;
  int cycles;
  bit no_idle;
  bit hold_req;

  bbt_in_if  in_if ();
  bbt_out_if out_if ();

  billboard_transform i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  bbt_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic bbt_pkg::fx_t rand_fx();
    case ($urandom_range(5))
      0, 1: return bbt_pkg::fx_t'($urandom);
      2:    return bbt_pkg::fx_t'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
      3:    return bbt_pkg::fx_t'($signed($urandom_range(32'h3ffffff)) - 32'sh2000000);
      4: begin
        case ($urandom_range(4))
          0: return FX_LO;
          1: return FX_HI;
          2: return 32'sd0;
          3: return FX_ONE;
          default: return -FX_ONE;
        endcase
      end
      default: return bbt_pkg::fx_t'($signed($urandom_range(32'h7ff)) - 32'sh400);
    endcase
  endfunction

  task automatic cfg_write(input logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bbt_pkg::DW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // let all columns drain before touching registers
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic set_regs(input bbt_pkg::mode_t m, input bbt_pkg::fx_t px,
                          input bbt_pkg::fx_t py, input bbt_pkg::fx_t pz,
                          input bbt_pkg::fx_t sx, input bbt_pkg::fx_t sy,
                          input bbt_pkg::fx_t sz);
    cfg_write(bbt_pkg::REG_MODE, bbt_pkg::DW'(m));
    cfg_write(bbt_pkg::REG_POS_X, px);
    cfg_write(bbt_pkg::REG_POS_Y, py);
    cfg_write(bbt_pkg::REG_POS_Z, pz);
    cfg_write(bbt_pkg::REG_SCALE_X, sx);
    cfg_write(bbt_pkg::REG_SCALE_Y, sy);
    cfg_write(bbt_pkg::REG_SCALE_Z, sz);
  endtask

  // one camera beat, called and returning at a falling edge
  task automatic send_cam(input bbt_pkg::fx_t cx, input bbt_pkg::fx_t cy,
                          input bbt_pkg::fx_t cz, input bbt_pkg::fx_t ux,
                          input bbt_pkg::fx_t uy, input bbt_pkg::fx_t uz);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cam_x <= cx;
    in_if.cam_y <= cy;
    in_if.cam_z <= cz;
    in_if.up_x  <= ux;
    in_if.up_y  <= uy;
    in_if.up_z  <= uz;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_cam(rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.cam_x = '0;
    in_if.cam_y = '0;
    in_if.cam_z = '0;
    in_if.up_x = '0;
    in_if.up_y = '0;
    in_if.up_z = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, zero camera, extremes
    send_cam(0, 0, 0, 0, FX_ONE, 0);
    send_cam(FX_ONE, 0, 0, 0, FX_ONE, 0);
    send_cam(FX_HI, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI);
    send_cam(FX_LO, FX_LO, FX_LO, FX_LO, FX_LO, FX_LO);
    send_cam(FX_LO, 0, FX_HI, FX_HI, FX_LO, 32'sd1);
    drain();
    set_regs(bbt_pkg::MODE_WORLD, FX_HI, FX_LO, 0, FX_ONE, FX_ONE, FX_ONE);
    cfg_write(REG_UNUSED, 32'hffffffff);
    send_cam(FX_HI, FX_HI, 0, 0, FX_ONE, 0);
    send_cam(FX_LO, FX_HI, FX_LO, FX_LO, FX_HI, FX_LO);
    send_cam(0, 0, 0, FX_ONE, 0, 0);
    drain();
    set_regs(bbt_pkg::MODE_WORLD, 0, 0, 0, FX_ONE, FX_ONE, FX_ONE);
    send_cam(0, 0, 0, 0, FX_ONE, 0);
    send_cam(0, 0, FX_ONE, 0, 0, FX_ONE);
    send_cam(3 * FX_ONE, 4 * FX_ONE, 0, 0, FX_ONE, 0);
    drain();
    set_regs(bbt_pkg::MODE_AXIS, FX_ONE, FX_LO, -FX_ONE, FX_HI, FX_LO, FX_HI);
    send_cam(FX_ONE, 0, -FX_ONE, 0, FX_ONE, 0);
    send_cam(FX_LO, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI);
    send_cam(FX_HI, 0, FX_LO, FX_LO, 0, 0);
    drain();
    set_regs(bbt_pkg::MODE_IDENT, FX_HI, FX_HI, FX_HI, FX_LO, FX_LO, FX_LO);
    send_cam(FX_HI, FX_HI, FX_HI, FX_HI, FX_HI, FX_HI);
    send_cam(0, 0, 0, 0, 0, 0);
    drain();
    set_regs(bbt_pkg::MODE_SCREEN, 0, 0, 0, FX_LO, FX_HI, 32'sd0);
    send_cam(FX_HI, 0, FX_HI, FX_HI, FX_LO, FX_HI);
    send_cam(FX_LO, FX_LO, FX_LO, FX_ONE, FX_ONE, FX_ONE);
    drain();

    // random phases over varied settings
    set_regs(bbt_pkg::MODE_SCREEN, rand_fx(), rand_fx(), rand_fx(), FX_ONE, FX_ONE, FX_ONE);
    send_random(40);
    hold_req = 1'b1;
    send_random(60);
    drain();
    set_regs(bbt_pkg::MODE_WORLD, rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
             rand_fx());
    send_random(50);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    send_random(40);
    drain();
    no_idle = 1'b1;
    set_regs(bbt_pkg::MODE_AXIS, rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
             rand_fx());
    send_random(80);
    drain();
    no_idle = 1'b0;
    set_regs(bbt_pkg::MODE_IDENT, rand_fx(), rand_fx(), rand_fx(), rand_fx(), rand_fx(),
             rand_fx());
    send_random(20);
    drain();
    set_regs(bbt_pkg::MODE_WORLD, FX_ONE, -FX_ONE, 32'sd0, FX_HI, FX_LO, FX_HI);
    send_random(50);
    drain();
    set_regs(bbt_pkg::MODE_SCREEN, FX_LO, FX_HI, FX_LO, rand_fx(), rand_fx(), rand_fx());
    send_random(50);
    drain();
    set_regs(bbt_pkg::MODE_AXIS, 32'sd0, 32'sd0, 32'sd0, FX_ONE, FX_ONE, FX_ONE);
    send_random(50);
    hold_req = 1'b1;
    send_random(40);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bbt_pkg.sv
design/bbt_if.sv
design/bbt_norm.sv
design/bbt_cross.sv
design/billboard_transform.sv
design/bbt_chk.sv
tb/bbt_checker.sv
tb/tb_billboard_transform.sv
